// ----- hw/rtl/twbc_pkg.sv -----
// Package for the trailing window bucket counter.
// Holds the sequencer state type and fixed sizes used by the top-level RTL file.
// No dependencies.
package twbc_pkg;

	localparam int unsigned CNT_W  = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned LANES  = 4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SETUP,
		ST_WALK,
		ST_RD,
		ST_UPD,
		ST_DONE
	} twbc_state_t;

endpackage

// ----- hw/rtl/trailing_window_bucket_counter_unit.sv -----
// Trailing window bucket counter: top level with APB registers and streams.
// Depends on twbc_pkg and twbc_ram.
//
// Each input word (count, now) returns one word with the short and long
// window totals. An item passes the bucket-index divider (four radix-2
// lanes: now and the previous time, by each bucket length), a setup state,
// a walk over the passed buckets of each window that also drains the ring
// read pipeline, then a read and a write-back of the head bucket. A gap
// of a whole ring or more clears it at once through per-bucket valid bits, so
// no clearing pass is needed after reset. The result sits in an output
// register; a new word is taken while it waits.
module trailing_window_bucket_counter_unit
	import twbc_pkg::*;
#(
	parameter int unsigned SHORT_BUCKETS = 60,
	parameter int unsigned LONG_BUCKETS  = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] count, [47:16] now
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [31:0] short_total, [63:32] long_total
);

	localparam int unsigned SHW = $clog2(SHORT_BUCKETS);
	localparam int unsigned LHW = $clog2(LONG_BUCKETS);

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {{(SUM_W+1-CNT_W){1'b0}}, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] floor_sub(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		return (a >= b) ? a - b : '0;
	endfunction

	twbc_state_t state_q, state_d;

	// configuration
	logic [LEN_W-1:0] short_spb_q, long_spb_q;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = paddr[2] ? {16'd0, long_spb_q} : {16'd0, short_spb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_spb_q <= LEN_W'(1);
			long_spb_q  <= LEN_W'(60);
		end else if (cfg_wr) begin
			if (paddr[2]) begin
				long_spb_q <= pwdata[LEN_W-1:0];
			end else begin
				short_spb_q <= pwdata[LEN_W-1:0];
			end
		end
	end

	// item registers
	logic [CNT_W-1:0]  count_q;
	logic [TIME_W-1:0] last_q;
	logic              in_acc;
	assign in_acc = s_tvalid && s_tready;

	// divider lanes: 0 now/short, 1 last/short, 2 now/long, 3 last/long
	logic [TIME_W-1:0] div_q_q [LANES];
	logic [LEN_W-1:0]  div_r_q [LANES];
	logic [LEN_W-1:0]  div_d_q [LANES];
	logic [4:0]        div_cnt_q;
	logic [LEN_W-1:0]  short_len, long_len;

	assign short_len = (short_spb_q == '0) ? LEN_W'(1) : short_spb_q;
	assign long_len  = (long_spb_q == '0) ? LEN_W'(1) : long_spb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q    <= '0;
			div_cnt_q <= '0;
		end else if (in_acc) begin
			last_q    <= s_tdata[47:16];
			div_cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			div_cnt_q <= div_cnt_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		logic [LEN_W:0] t;
		logic           ge;
		if (in_acc) begin
			count_q    <= s_tdata[15:0];
			div_q_q[0] <= s_tdata[47:16];
			div_q_q[1] <= last_q;
			div_q_q[2] <= s_tdata[47:16];
			div_q_q[3] <= last_q;
			div_d_q[0] <= short_len;
			div_d_q[1] <= short_len;
			div_d_q[2] <= long_len;
			div_d_q[3] <= long_len;
			for (int i = 0; i < LANES; i++) begin
				div_r_q[i] <= '0;
			end
		end else if (state_q == ST_DIV) begin
			for (int i = 0; i < LANES; i++) begin
				t  = {div_r_q[i], div_q_q[i][TIME_W-1]};
				ge = (t >= {1'b0, div_d_q[i]});
				div_q_q[i] <= {div_q_q[i][TIME_W-2:0], ge};
				div_r_q[i] <= ge ? LEN_W'(t - {1'b0, div_d_q[i]}) : t[LEN_W-1:0];
			end
		end
	end

	// window gaps
	logic [TIME_W-1:0] s_gap, l_gap;
	assign s_gap = div_q_q[0] - div_q_q[1];
	assign l_gap = div_q_q[2] - div_q_q[3];

	// ---------------- short window ----------------
	logic [SHW-1:0]           s_head_q, s_head_nx, s_rem_q, s_raddr;
	logic [SHORT_BUCKETS-1:0] s_vld_q;
	logic [SUM_W-1:0]         s_sum_q, s_rdata, s_old, s_new;
	logic                     s_pend_s1, s_pv_s1, s_hv_s1, s_we;

	assign s_head_nx = (s_head_q == SHW'(SHORT_BUCKETS - 1)) ? '0 : s_head_q + SHW'(1);
	assign s_old     = s_hv_s1 ? s_rdata : '0;
	assign s_new     = sat_add(s_old, count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_head_q  <= '0;
			s_rem_q   <= '0;
			s_vld_q   <= '0;
			s_sum_q   <= '0;
			s_pend_s1 <= 1'b0;
			s_pv_s1   <= 1'b0;
			s_hv_s1   <= 1'b0;
		end else begin
			s_pend_s1 <= 1'b0;
			if (s_pend_s1) begin
				s_sum_q <= floor_sub(s_sum_q, s_pv_s1 ? s_rdata : '0);
			end
			unique case (state_q)
				ST_SETUP: begin
					if (div_q_q[0] > div_q_q[1]) begin
						if (s_gap >= TIME_W'(SHORT_BUCKETS)) begin
							s_vld_q <= '0;
							s_sum_q <= '0;
							s_rem_q <= '0;
						end else begin
							s_rem_q <= s_gap[SHW-1:0];
						end
					end else begin
						s_rem_q <= '0;
					end
				end
				ST_WALK: begin
					if (s_rem_q != '0) begin
						s_head_q          <= s_head_nx;
						s_rem_q           <= s_rem_q - SHW'(1);
						s_pend_s1         <= 1'b1;
						s_pv_s1           <= s_vld_q[s_head_nx];
						s_vld_q[s_head_nx] <= 1'b0;
					end
				end
				ST_RD: begin
					s_hv_s1 <= s_vld_q[s_head_q];
				end
				ST_UPD: begin
					s_vld_q[s_head_q] <= 1'b1;
					s_sum_q           <= sat_add(s_sum_q, count_q);
				end
				default: ;
			endcase
		end
	end

	twbc_ram #(.WIDTH(SUM_W), .DEPTH(SHORT_BUCKETS)) u_short_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_head_q),
		.wdata (s_new),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// ---------------- long window ----------------
	logic [LHW-1:0]          l_head_q, l_head_nx, l_rem_q, l_raddr;
	logic [LONG_BUCKETS-1:0] l_vld_q;
	logic [SUM_W-1:0]        l_sum_q, l_rdata, l_old, l_new;
	logic                    l_pend_s1, l_pv_s1, l_hv_s1, l_we;

	assign l_head_nx = (l_head_q == LHW'(LONG_BUCKETS - 1)) ? '0 : l_head_q + LHW'(1);
	assign l_old     = l_hv_s1 ? l_rdata : '0;
	assign l_new     = sat_add(l_old, count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_head_q  <= '0;
			l_rem_q   <= '0;
			l_vld_q   <= '0;
			l_sum_q   <= '0;
			l_pend_s1 <= 1'b0;
			l_pv_s1   <= 1'b0;
			l_hv_s1   <= 1'b0;
		end else begin
			l_pend_s1 <= 1'b0;
			if (l_pend_s1) begin
				l_sum_q <= floor_sub(l_sum_q, l_pv_s1 ? l_rdata : '0);
			end
			unique case (state_q)
				ST_SETUP: begin
					if (div_q_q[2] > div_q_q[3]) begin
						if (l_gap >= TIME_W'(LONG_BUCKETS)) begin
							l_vld_q <= '0;
							l_sum_q <= '0;
							l_rem_q <= '0;
						end else begin
							l_rem_q <= l_gap[LHW-1:0];
						end
					end else begin
						l_rem_q <= '0;
					end
				end
				ST_WALK: begin
					if (l_rem_q != '0) begin
						l_head_q          <= l_head_nx;
						l_rem_q           <= l_rem_q - LHW'(1);
						l_pend_s1         <= 1'b1;
						l_pv_s1           <= l_vld_q[l_head_nx];
						l_vld_q[l_head_nx] <= 1'b0;
					end
				end
				ST_RD: begin
					l_hv_s1 <= l_vld_q[l_head_q];
				end
				ST_UPD: begin
					l_vld_q[l_head_q] <= 1'b1;
					l_sum_q           <= sat_add(l_sum_q, count_q);
				end
				default: ;
			endcase
		end
	end

	twbc_ram #(.WIDTH(SUM_W), .DEPTH(LONG_BUCKETS)) u_long_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_head_q),
		.wdata (l_new),
		.raddr (l_raddr),
		.rdata (l_rdata)
	);

	// ---------------- sequencer ----------------
	logic walk_done, out_free;
	assign walk_done = (s_rem_q == '0) && (l_rem_q == '0) && !s_pend_s1 && !l_pend_s1;
	assign out_free  = !m_tvalid || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_DIV;
			ST_DIV:   if (div_cnt_q == 5'd31) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_WALK;
			ST_WALK:  if (walk_done) state_d = ST_RD;
			ST_RD:    state_d = ST_UPD;
			ST_UPD:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		s_we     = (state_q == ST_UPD);
		l_we     = (state_q == ST_UPD);
		s_raddr  = (state_q == ST_WALK) ? s_head_nx : s_head_q;
		l_raddr  = (state_q == ST_WALK) ? l_head_nx : l_head_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= {l_sum_q, s_sum_q};
		end
	end

	// ---------------- assertions ----------------
	a_acc_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q == ST_DIV)
		else $error("accepted word did not start the divider");

	a_walk_dec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |=> s_rem_q <= $past(s_rem_q) && l_rem_q <= $past(l_rem_q))
		else $error("bucket walk count grew");

	a_upd_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> !s_pend_s1 && !l_pend_s1)
		else $error("head update with ring reads still pending");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result shown outside the done state");

endmodule

// ----- hw/rtl/twbc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Used for the bucket rings. No dependencies.
module twbc_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 60
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
